// File: rtl/siq_pkg.sv
package siq_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        CMD_APPEND   = 2'd0,
        CMD_INS_DESC = 2'd1,
        CMD_INS_ASC  = 2'd2,
        CMD_REMOVE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] removed_value;
        logic [31:0] head_value;
        logic        head_valid;
        logic [4:0]  entry_count;
    } t_rsp;

    // Broadcast combinationally to every cell of the chain.
    typedef struct packed {
        t_op                    op;
        t_cmd                   cmd;
        logic [VALUE_WIDTH-1:0] value;
        logic                   cmp_signed;
    } t_cell_ctl;

endpackage

// File: rtl/siq_cell.sv
module siq_cell
    import siq_pkg::*;
(
    input  logic                   i_clk,
    input  t_cell_ctl              i_ctl,
    input  logic                   i_occupied,
    input  logic                   i_pass_in,
    output logic                   o_pass_out,
    input  logic [VALUE_WIDTH-1:0] i_left_data,
    input  logic [VALUE_WIDTH-1:0] i_right_data,
    output logic [VALUE_WIDTH-1:0] o_data,
    output logic [VALUE_WIDTH-1:0] o_next
);

    logic [VALUE_WIDTH-1:0] r_data;
    logic [VALUE_WIDTH-1:0] n_data;
    logic [VALUE_WIDTH-1:0] w_flip;
    logic [VALUE_WIDTH-1:0] w_a;
    logic [VALUE_WIDTH-1:0] w_b;
    logic                   w_pass_here;

    // Flip the sign bit so an unsigned compare orders two's complement values.
    assign w_flip = {i_ctl.cmp_signed, {(VALUE_WIDTH-1){1'b0}}};
    assign w_a    = r_data ^ w_flip;
    assign w_b    = i_ctl.value ^ w_flip;

    always_comb begin
        unique case (i_ctl.cmd)
            CMD_APPEND:   w_pass_here = i_occupied;
            CMD_INS_DESC: w_pass_here = i_occupied && (w_a > w_b);
            CMD_INS_ASC:  w_pass_here = i_occupied && (w_a < w_b);
            CMD_REMOVE:   w_pass_here = 1'b0;
            default:      w_pass_here = 1'b0;
        endcase
    end

    assign o_pass_out = i_pass_in & w_pass_here;

    always_comb begin
        unique case (i_ctl.op)
            OP_INSERT: begin
                if (!i_pass_in) begin
                    n_data = i_left_data;
                end else if (!w_pass_here) begin
                    n_data = i_ctl.value;
                end else begin
                    n_data = r_data;
                end
            end
            OP_REMOVE: n_data = i_right_data;
            default:   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_next = n_data;

endmodule

// File: rtl/sorted_insert_queue.sv
// Bounded queue of 16 values of 32 bits with four commands: append at the
// tail, descending insert (before the first entry that is not greater),
// ascending insert (before the first entry that is not less) and remove of
// the head. A sorted insert that passes every entry lands at the tail; an
// insert into a full queue is dropped with status 1, a remove from an empty
// queue reports status 2 and removed_value 0. Every request gives exactly
// one response carrying status, removed value, new head, head_valid and the
// new count. The queue takes one request per cycle; its response appears in
// the output register the cycle after acceptance and the next request is
// taken in that same cycle as long as the response is taken too. Each cycle
// the entries sit in a row of cells: every cell compares its entry with the
// new value in parallel, a pass flag ripples down the row to locate the
// insert slot, and each cell then holds, loads the new value or loads its
// left neighbor (insert) or right neighbor (remove). That ripple across all
// cells sets the cycle time. compare_signed (write on the cfg channel while
// idle) selects two's complement ordering; reset leaves it at unsigned.
module sorted_insert_queue
    import siq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    // request channel
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    // response channel
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp,
    // configuration channel
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data
);

    logic               r_cfg_signed;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_rsp_valid;
    logic               n_rsp_valid;
    t_rsp               r_rsp;
    t_rsp               n_rsp;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    t_cell_ctl w_ctl;

    logic                   w_pass [0:CAPACITY];
    logic [VALUE_WIDTH-1:0] w_data [0:CAPACITY-1];
    logic [VALUE_WIDTH-1:0] w_next [0:CAPACITY-1];

    // Take a new request whenever the response register is free or draining.
    assign o_req_ready = !r_rsp_valid || i_rsp_ready;
    assign w_accept    = i_req_valid && o_req_ready;
    assign o_cfg_ready = 1'b1;

    assign w_full  = (r_count == COUNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    // Broadcast the command to the row; only an accepted request moves data.
    always_comb begin
        w_ctl.cmd        = i_req.cmd;
        w_ctl.value      = i_req.value[VALUE_WIDTH-1:0];
        w_ctl.cmp_signed = r_cfg_signed;
        w_ctl.op         = OP_HOLD;
        if (w_accept) begin
            if (i_req.cmd == CMD_REMOVE) begin
                if (!w_empty) begin
                    w_ctl.op = OP_REMOVE;
                end
            end else if (!w_full) begin
                w_ctl.op = OP_INSERT;
            end
        end
    end

    // Head of the chain: nothing ahead of slot 0 to pass.
    assign w_pass[0] = 1'b1;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_left;
        logic [VALUE_WIDTH-1:0] w_right;
        logic                   w_occ;

        if (g == 0) begin : g_first
            assign w_left = w_ctl.value;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        assign w_occ = (COUNT_W'(g) < r_count);

        siq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_occupied   (w_occ),
            .i_pass_in    (w_pass[g]),
            .o_pass_out   (w_pass[g+1]),
            .i_left_data  (w_left),
            .i_right_data (w_right),
            .o_data       (w_data[g]),
            .o_next       (w_next[g])
        );
    end

    // Count update and response build from the row's next values.
    always_comb begin
        n_count     = r_count;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;

        unique case (w_ctl.op)
            OP_INSERT: n_count = r_count + COUNT_W'(1);
            OP_REMOVE: n_count = r_count - COUNT_W'(1);
            default:   n_count = r_count;
        endcase

        if (w_accept) begin
            n_rsp_valid         = 1'b1;
            n_rsp.status        = ST_OK;
            n_rsp.removed_value = '0;
            if (i_req.cmd == CMD_REMOVE) begin
                if (w_empty) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    n_rsp.removed_value = 32'(w_data[0]);
                end
            end else if (w_full) begin
                n_rsp.status = ST_FULL;
            end
            n_rsp.head_valid  = (n_count != '0);
            n_rsp.head_value  = (n_count != '0) ? 32'(w_next[0]) : 32'd0;
            n_rsp.entry_count = 5'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_rsp_valid  <= 1'b0;
            r_cfg_signed <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg_signed <= i_cfg_data;
            end
        end
    end

    // Response payload needs no reset; valid guards it.
    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// File: rtl/siq_checker.sv
module siq_checker
    import siq_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input t_req i_req,
    input logic o_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp o_rsp,
    input logic i_cfg_valid,
    input logic o_cfg_ready,
    input logic i_cfg_data
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response changed while stalled");

    a_req_to_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> o_rsp_valid)
        else $error("accepted request gave no response");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.head_valid == (o_rsp.entry_count != 5'd0)))
        else $error("head_valid disagrees with count");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status == ST_EMPTY |->
            o_rsp.removed_value == 32'd0 && o_rsp.entry_count == 5'd0)
        else $error("empty remove reported data");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status == ST_FULL |->
            o_rsp.entry_count == 5'(CAPACITY))
        else $error("full status without full count");

endmodule

bind sorted_insert_queue siq_checker u_siq_checker (.*);
